/* rtl/core/lhmt_pkg.sv */
// types, constants and helpers shared by the label histogram files
package lhmt_pkg;

  // opcodes of an input word; the unused code behaves as a query
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // pass of the token running along the cell chain
  localparam logic PH_SEARCH = 1'b0;
  localparam logic PH_APPLY  = 1'b1;

  // enough for a table of up to 256 labels
  localparam int unsigned DIST_W = 9;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] label;
    logic [15:0] amount;
  } lhmt_in_t;

  typedef struct packed {
    logic [31:0] label_count;
    logic [31:0] total_rows;
    logic [4:0]  distinct_labels;
    logic        single_label;
    logic [15:0] mode_label;
    logic [31:0] mode_count;
    logic [31:0] minority_count;
    logic [15:0] smallest_label;
    logic        table_nonempty;
    logic        dropped_full;
  } lhmt_out_t;

  // token handed from cell to cell
  typedef struct packed {
    logic              phase;
    logic [1:0]        opcode;
    logic [15:0]       label;
    logic [15:0]       amount;
    logic              hit;
    logic              free;
    logic              insert;
    logic              claimed;
    logic [31:0]       lcount;
    logic              best_any;
    logic [15:0]       best_label;
    logic [31:0]       best_count;
    logic [DIST_W-1:0] distinct;
    logic              nonempty;
    logic [15:0]       smallest;
  } scan_tok_t;

  // saturating add of a 16-bit amount to a 32-bit count
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

/* rtl/core/label_histogram_mode_tracker_top.sv */
// top level of the label histogram with running mode
//
// usage:
//   - an input word (opcode, label, amount) is taken on a rising edge with
//     start high and busy low; busy stays high while the word is processed
//   - opcodes: add amount to a label (inserting it if new), clear the table
//     and total, query one label's count; the unused code acts as a query
//   - one result word per input word, shown on out_word for a single cycle
//     with out_valid high; the receiver cannot stall, so it must take it then
//   - the table lives in a row of LABELS cells; a token walks the row one
//     cell per cycle, once to look the label up and once to apply the
//     update and gather mode, distinct count and smallest label
//   - out_valid goes high in the same cycle that busy drops, so the next
//     word can be taken in that same cycle; a new word waits until both
//     walks of the chain are done
//   - an add of a new label to a full table changes nothing and sets
//     dropped_full in its result
//   - reset (rst_n low, synchronous) empties the table and zeroes total,
//     mode label, mode count and minority count
module label_histogram_mode_tracker_top import lhmt_pkg::*; #(
  parameter int unsigned LABELS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  lhmt_in_t  in_word,
  output logic      out_valid,
  output lhmt_out_t out_word
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] total_r, total_nxt;
  logic [15:0] best_label_r, best_label_nxt;
  logic [31:0] best_count_r, best_count_nxt;
  logic [31:0] rest_count_r, rest_count_nxt;
  logic        out_valid_r, out_valid_nxt;
  lhmt_out_t   out_word_r, out_word_nxt;

  // token chain: tok[0] is injected here, tok[LABELS] leaves the last cell
  scan_tok_t   tok [LABELS+1];
  logic [LABELS:0] tok_vld;
  scan_tok_t   fresh_tok, apply_tok, chain_out;
  logic        chain_vld;
  logic        dropped;

  assign chain_out = tok[LABELS];
  assign chain_vld = tok_vld[LABELS];

  // lookup found neither the label nor a free entry
  assign dropped = (chain_out.opcode == OP_ADD) && !chain_out.hit && !chain_out.free;

  genvar gi;
  generate
    for (gi = 0; gi < LABELS; gi++) begin : g_cell
      lhmt_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_vld_i (tok_vld[gi]),
        .tok_i     (tok[gi]),
        .tok_vld_o (tok_vld[gi+1]),
        .tok_o     (tok[gi+1])
      );
    end
  endgenerate

  always_comb begin
    fresh_tok        = '0;
    fresh_tok.phase  = PH_SEARCH;
    fresh_tok.opcode = in_word.opcode;
    fresh_tok.label  = in_word.label;
    fresh_tok.amount = in_word.amount;

    // second walk carries the lookup flags and starts fresh statistics
    apply_tok            = chain_out;
    apply_tok.phase      = PH_APPLY;
    apply_tok.insert     = (chain_out.opcode == OP_ADD) && !chain_out.hit && chain_out.free;
    apply_tok.claimed    = 1'b0;
    apply_tok.lcount     = '0;
    apply_tok.best_any   = 1'b0;
    apply_tok.best_label = '0;
    apply_tok.best_count = '0;
    apply_tok.distinct   = '0;
    apply_tok.nonempty   = 1'b0;
    apply_tok.smallest   = '0;
  end

  assign tok_vld[0] = ((state_r == ST_IDLE) && start) || ((state_r == ST_SCAN) && chain_vld);
  assign tok[0]     = (state_r == ST_SCAN) ? apply_tok : fresh_tok;

  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    best_label_nxt = best_label_r;
    best_count_nxt = best_count_r;
    rest_count_nxt = rest_count_r;
    out_valid_nxt  = 1'b0;
    out_word_nxt   = out_word_r;

    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (chain_vld) begin
          state_nxt = ST_APPLY;
          // total moves once the lookup is known
          if (chain_out.opcode == OP_ADD && (chain_out.hit || chain_out.free))
            total_nxt = sat_add(total_r, chain_out.amount);
          else if (chain_out.opcode == OP_CLEAR)
            total_nxt = '0;
        end
      end
      ST_APPLY: begin
        if (chain_vld) begin
          state_nxt = ST_IDLE;
          if (chain_out.opcode == OP_ADD && !dropped && chain_out.best_any) begin
            best_label_nxt = chain_out.best_label;
            best_count_nxt = chain_out.best_count;
            rest_count_nxt = (total_r >= chain_out.best_count) ?
                             total_r - chain_out.best_count : 32'd0;
          end
          out_valid_nxt                = 1'b1;
          out_word_nxt.label_count     = chain_out.lcount;
          out_word_nxt.total_rows      = total_r;
          out_word_nxt.distinct_labels = chain_out.distinct[4:0];
          out_word_nxt.single_label    = (chain_out.distinct == DIST_W'(1));
          out_word_nxt.mode_label      = best_label_nxt;
          out_word_nxt.mode_count      = best_count_nxt;
          out_word_nxt.minority_count  = rest_count_nxt;
          out_word_nxt.smallest_label  = chain_out.smallest;
          out_word_nxt.table_nonempty  = chain_out.nonempty;
          out_word_nxt.dropped_full    = dropped;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      total_r      <= '0;
      best_label_r <= '0;
      best_count_r <= '0;
      rest_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      best_label_r <= best_label_nxt;
      best_count_r <= best_count_nxt;
      rest_count_r <= rest_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // only one token walks the chain at a time
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld[LABELS:1]))
    else $error("more than one token in the cell chain");

  // a result is only shown once the block is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // an accepted word starts the lookup walk
  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_SCAN) && tok_vld[1])
    else $error("accepted word did not enter the chain");

  // a dropped add reports no count and leaves the total alone
  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.dropped_full) |->
      (out_word.label_count == 32'd0) && (out_word.total_rows == $past(total_r, 2)))
    else $error("dropped add changed visible state");

endmodule

/* rtl/core/lhmt_cell.sv */
// one table entry of the label histogram and its stage of the token chain
module lhmt_cell import lhmt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      tok_vld_i,
  input  scan_tok_t tok_i,
  output logic      tok_vld_o,
  output scan_tok_t tok_o
);

  logic        valid_r, valid_nxt;
  logic [15:0] label_r, label_nxt;
  logic [31:0] count_r, count_nxt;
  logic        tok_vld_r;
  scan_tok_t   tok_r, tok_nxt;
  logic        match;
  logic        apply;

  assign match = valid_r && (label_r == tok_i.label);
  assign apply = tok_vld_i && (tok_i.phase == PH_APPLY);

  always_comb begin
    tok_nxt   = tok_i;
    valid_nxt = valid_r;
    label_nxt = label_r;
    count_nxt = count_r;
    if (tok_i.phase == PH_SEARCH) begin
      if (match) tok_nxt.hit = 1'b1;
      if (!valid_r) tok_nxt.free = 1'b1;
    end else begin
      case (tok_i.opcode)
        OP_ADD: begin
          if (match) begin
            count_nxt      = sat_add(count_r, tok_i.amount);
            tok_nxt.lcount = count_nxt;
          end else if (!valid_r && tok_i.insert && !tok_i.claimed) begin
            // lowest free entry takes the new label
            valid_nxt       = 1'b1;
            label_nxt       = tok_i.label;
            count_nxt       = {16'b0, tok_i.amount};
            tok_nxt.claimed = 1'b1;
            tok_nxt.lcount  = count_nxt;
          end
        end
        OP_CLEAR: valid_nxt = 1'b0;
        default: begin
          if (match) tok_nxt.lcount = count_r;
        end
      endcase
      // fold the updated entry into the running statistics
      if (valid_nxt) begin
        tok_nxt.distinct = tok_i.distinct + DIST_W'(1);
        if (!tok_i.nonempty || label_nxt < tok_i.smallest) tok_nxt.smallest = label_nxt;
        tok_nxt.nonempty = 1'b1;
        if (!tok_i.best_any || count_nxt > tok_i.best_count ||
            (count_nxt == tok_i.best_count && label_nxt < tok_i.best_label)) begin
          tok_nxt.best_any   = 1'b1;
          tok_nxt.best_label = label_nxt;
          tok_nxt.best_count = count_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_i;
      if (apply) valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (apply) begin
      label_r <= label_nxt;
      count_r <= count_nxt;
    end
  end

  assign tok_vld_o = tok_vld_r;
  assign tok_o     = tok_r;

endmodule
